// ===== hdl/bfa_pkg.sv =====
// shared types and codes of the bitmap frame allocator
package bfa_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_ALLOC = 2'd0;
    localparam opcode_t OP_FREE  = 2'd1;
    localparam opcode_t OP_MARK  = 2'd2;
    localparam opcode_t OP_STAT  = 2'd3;

    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_END   = 1'b1;

    // bitmap word width, frame addresses split by shift and mask
    localparam int WORD_BITS = 64;

    localparam int POS_W = 18;
    localparam int LEN_W = 17;

    typedef struct packed {
        logic clr;
        logic start;
        logic rd;
        logic a_ev;
        logic wr;
        logic s_ev;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    zero_len;
        logic    clr_last;
        logic    a_hit;
        logic    a_fail;
        logic    a_next;
        logic    w_stop;
        logic    s_stop;
    } sts_t;

endpackage

// ===== hdl/bitmap_frame_allocator.sv =====
// top level of the first-fit bitmap frame allocator
// One request at a time. After reset the bitmap is cleared one word per cycle
// and no request is taken until that pass ends. Allocate reads the bitmap word
// by word from range_start, stepping past each used frame met inside a word,
// then sets the run word by word, reading and writing each word. Free and mark
// read and write each word touched; statistics reads and counts each word of
// the range. Every request also passes through a setup state and a result
// state. A result is held until taken; the next request is taken in the cycle
// the result leaves. Configuration writes are always ready.
module bitmap_frame_allocator #(
    parameter int FRAME_COUNT = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] first_frame,
    input  logic [16:0] run_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] start_frame,
    output logic [16:0] used_frames,
    output logic [16:0] total_frames
);

    bfa_pkg::cmd_t cmd;
    bfa_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_datapath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .first_frame  (first_frame),
        .run_length   (run_length),
        .status       (status),
        .start_frame  (start_frame),
        .used_frames  (used_frames),
        .total_frames (total_frames)
    );

endmodule

// ===== hdl/bfa_datapath.sv =====
// bitmap memory, scan counters and result registers of the frame allocator
module bfa_datapath #(
    parameter int FRAME_COUNT = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfa_pkg::cmd_t         cmd,
    output bfa_pkg::sts_t         sts,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_data,
    input  bfa_pkg::opcode_t      opcode,
    input  logic [15:0]           first_frame,
    input  logic [16:0]           run_length,
    output logic                  status,
    output logic [15:0]           start_frame,
    output logic [16:0]           used_frames,
    output logic [16:0]           total_frames
);

    localparam int WORD_BITS  = bfa_pkg::WORD_BITS;
    localparam int WL         = $clog2(WORD_BITS);
    localparam int CW         = WL + 1;
    localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PW         = bfa_pkg::POS_W;
    localparam int XW         = (AW + 1 > PW) ? AW + 1 : PW;
    localparam int LAST_BITS  = FRAME_COUNT - (WORD_COUNT - 1) * WORD_BITS;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [16:0]            rs_reg, re_reg;
    logic [XW-1:0]          wix_reg, wix_next;
    logic [WL-1:0]          off_reg, off_next;
    logic [PW-1:0]          cand_reg, cand_next;
    logic [16:0]            cnt_reg, cnt_next;
    logic [16:0]            rem_reg, rem_next;
    logic [16:0]            acc_reg, acc_next;
    logic [16:0]            len_reg;
    bfa_pkg::opcode_t       op_reg;
    logic                   fail_reg, fail_next;

    logic [PW-1:0]          pos_init;
    logic [XW-1:0]          re_word;
    logic                   in_store;
    logic [CW-1:0]          end_lim, exist_lim, lim, fu, avail;
    logic [WORD_BITS-1:0]   blk, wmask, new_word;
    logic [PW-1:0]          run_sum;
    logic [CW-1:0]          pc;
    logic                   hit, fail;
    logic [16:0]            tot;

    assign re_word  = XW'(re_reg >> WL);
    assign in_store = wix_reg < XW'(WORD_COUNT);
    assign pos_init = (opcode == bfa_pkg::OP_FREE || opcode == bfa_pkg::OP_MARK)
                      ? PW'(first_frame) : PW'(rs_reg);

    // how far into the current word frames may be used
    always_comb
    begin
        if (wix_reg < re_word)
            end_lim = CW'(WORD_BITS);
        else if (wix_reg == re_word)
            end_lim = CW'(re_reg[WL-1:0]);
        else
            end_lim = '0;
        if (wix_reg < XW'(WORD_COUNT - 1))
            exist_lim = CW'(WORD_BITS);
        else if (wix_reg == XW'(WORD_COUNT - 1))
            exist_lim = CW'(LAST_BITS);
        else
            exist_lim = '0;
        lim = (end_lim < exist_lim) ? end_lim : exist_lim;
    end

    // first blocking frame at or after the current offset
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
            blk[i] = (CW'(i) >= CW'(off_reg)) && (rd_data_reg[i] || CW'(i) >= lim);
        fu = CW'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
            if (blk[i])
                fu = CW'(i);
    end

    assign run_sum = PW'(cnt_reg) + PW'(fu - CW'(off_reg));
    assign hit     = run_sum >= PW'(len_reg);
    assign fail    = !hit && (fu >= lim) && (lim < CW'(WORD_BITS));

    // run mask for set and clear
    assign avail = CW'(WORD_BITS) - CW'(off_reg);
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
            wmask[i] = (CW'(i) >= CW'(off_reg))
                       && (PW'(i) < PW'(off_reg) + PW'(rem_reg))
                       && (CW'(i) < exist_lim);
        new_word = (op_reg == bfa_pkg::OP_FREE) ? (rd_data_reg & ~wmask)
                                                 : (rd_data_reg | wmask);
    end

    always_comb
    begin
        pc = '0;
        for (int i = 0; i < WORD_BITS; i++)
            pc = pc + CW'(rd_data_reg[i]);
    end

    assign tot = (re_reg > rs_reg) ? (re_reg - rs_reg) : 17'd0;

    always_comb
    begin
        wix_next  = wix_reg;
        off_next  = off_reg;
        cand_next = cand_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        fail_next = fail_reg;
        if (cmd.clr)
        begin
            wix_next = wix_reg + XW'(1);
        end
        else if (cmd.start)
        begin
            wix_next  = XW'(pos_init >> WL);
            off_next  = pos_init[WL-1:0];
            cand_next = PW'(rs_reg);
            cnt_next  = '0;
            rem_next  = run_length;
            acc_next  = '0;
            fail_next = 1'b0;
        end
        else if (cmd.a_ev)
        begin
            if (hit)
            begin
                wix_next = XW'(cand_reg >> WL);
                off_next = cand_reg[WL-1:0];
                rem_next = len_reg;
            end
            else if (fail)
            begin
                fail_next = 1'b1;
            end
            else if (fu == CW'(WORD_BITS))
            begin
                cnt_next = cnt_reg + 17'(avail);
                wix_next = wix_reg + XW'(1);
                off_next = '0;
            end
            else
            begin
                cand_next = PW'((wix_reg << WL) + XW'(fu) + XW'(1));
                cnt_next  = '0;
                if (fu == CW'(WORD_BITS - 1))
                begin
                    wix_next = wix_reg + XW'(1);
                    off_next = '0;
                end
                else
                begin
                    off_next = WL'(fu + CW'(1));
                end
            end
        end
        else if (cmd.wr)
        begin
            rem_next = (rem_reg > 17'(avail)) ? (rem_reg - 17'(avail)) : 17'd0;
            wix_next = wix_reg + XW'(1);
            off_next = '0;
        end
        else if (cmd.s_ev)
        begin
            if (in_store)
                acc_next = acc_reg + 17'(pc);
            wix_next = wix_reg + XW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg  <= 17'd0;
            re_reg  <= 17'd65536;
            wix_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == bfa_pkg::REG_RANGE_START)
                rs_reg <= cfg_data;
            if (cfg_valid && cfg_index == bfa_pkg::REG_RANGE_END)
                re_reg <= cfg_data;
            wix_reg <= wix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        cand_reg <= cand_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        fail_reg <= fail_next;
        if (cmd.start)
        begin
            op_reg  <= opcode;
            len_reg <= run_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr || (cmd.wr && in_store))
            mem[wix_reg[AW-1:0]] <= cmd.clr ? '0 : new_word;
        if (cmd.rd && in_store)
            rd_data_reg <= mem[wix_reg[AW-1:0]];
    end

    assign sts.op       = op_reg;
    assign sts.zero_len = (len_reg == 17'd0);
    assign sts.clr_last = (wix_reg == XW'(WORD_COUNT - 1));
    assign sts.a_hit    = hit;
    assign sts.a_fail   = fail;
    assign sts.a_next   = !hit && !fail && (fu >= CW'(WORD_BITS - 1));
    assign sts.w_stop   = (rem_reg == 17'd0) || !in_store;
    assign sts.s_stop   = (wix_reg >= re_word);

    assign status       = fail_reg;
    assign start_frame  = (op_reg == bfa_pkg::OP_ALLOC && !fail_reg) ? cand_reg[15:0] : 16'd0;
    assign used_frames  = (op_reg == bfa_pkg::OP_STAT) ? acc_reg : 17'd0;
    assign total_frames = (op_reg == bfa_pkg::OP_STAT) ? tot : 17'd0;

endmodule

// ===== hdl/bfa_ctrl.sv =====
// sequencer of the frame allocator: clearing pass, scans and result handshake
module bfa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  bfa_pkg::sts_t sts,
    output bfa_pkg::cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_GO    = 4'd2;
    localparam logic [3:0] S_A_RD  = 4'd3;
    localparam logic [3:0] S_A_EV  = 4'd4;
    localparam logic [3:0] S_W_RD  = 4'd5;
    localparam logic [3:0] S_W_WR  = 4'd6;
    localparam logic [3:0] S_S_RD  = 4'd7;
    localparam logic [3:0] S_S_EV  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_stall  = !(state_reg == S_IDLE && (!out_valid_reg || !out_stall));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                unique case (sts.op)
                    bfa_pkg::OP_ALLOC: state_next = sts.zero_len ? S_FIN : S_A_RD;
                    bfa_pkg::OP_STAT:  state_next = S_S_RD;
                    default:           state_next = S_W_RD;
                endcase
            end
            S_A_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                cmd.a_ev = 1'b1;
                if (sts.a_hit)
                    state_next = S_W_RD;
                else if (sts.a_fail)
                    state_next = S_FIN;
                else if (sts.a_next)
                    state_next = S_A_RD;
            end
            S_W_RD:
            begin
                if (sts.w_stop)
                    state_next = S_FIN;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_W_WR;
                end
            end
            S_W_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = S_W_RD;
            end
            S_S_RD:
            begin
                if (sts.s_stop)
                    state_next = S_FIN;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_S_EV;
                end
            end
            S_S_EV:
            begin
                cmd.s_ev   = 1'b1;
                state_next = S_S_RD;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == S_FIN)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
